// ===== hw/rtl/tsr_pkg.sv =====
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types and constants of the text scrollback ring.
// ----------------------------------------------------------------------------
`default_nettype none

package tsr_pkg;

    localparam int ROWS_DEF     = 32;
    localparam int COLS_DEF     = 80;
    localparam int CONSOLES_DEF = 4;

    // widest values over the parameter ranges
    localparam int CON_W   = 4;
    localparam int ROW_W   = 8;
    localparam int COL_W   = 8;
    localparam int SHOWN_W = 6;
    localparam int CCOL_W  = 7;
    localparam int VROW_W  = 5;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LEN,
        OP_CHAR,
        OP_CLEAR,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [CON_W-1:0]    console;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [COL_W-1:0]    len;
        logic [7:0]          chr;
        logic [VROW_W-1:0]   view_row;
        logic                hit;
        logic [SHOWN_W-1:0]  shown;
        logic [CCOL_W-1:0]   cursor_col;
    } t_mem_req;

    typedef struct packed {
        logic                hit;
        logic [COL_W-1:0]    col;
        logic [SHOWN_W-1:0]  shown;
        logic [CCOL_W-1:0]   cursor_col;
    } t_rd_info;

endpackage

`default_nettype wire

// ===== hw/rtl/tsr_console_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsr_console_ctrl
// Per-console cursor state, put/clear rules and read window arithmetic.
// Emits one registered memory request per accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_console_ctrl #(
    parameter int ROWS     = tsr_pkg::ROWS_DEF,
    parameter int COLS     = tsr_pkg::COLS_DEF,
    parameter int CONSOLES = tsr_pkg::CONSOLES_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_accept,
    input  wire  [1:0]                     i_cmd,
    input  wire  [1:0]                     i_instance_req,
    input  wire  [7:0]                     i_char_code,
    input  wire  [5:0]                     i_window_rows,
    input  wire  [4:0]                     i_view_row,
    input  wire  [6:0]                     i_view_col,
    output tsr_pkg::t_mem_req              o_req
);

    localparam int RW  = $clog2(ROWS);
    localparam int CNW = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;
    localparam int SW  = (RW + 1 > 6) ? RW + 1 : 6;
    localparam int CW  = tsr_pkg::COL_W;

    logic [RW-1:0]       r_cur_row [CONSOLES];
    logic [CW-1:0]       r_cur_col [CONSOLES];
    logic [CONSOLES-1:0] r_filled;
    tsr_pkg::t_mem_req   r_req;

    logic [CNW-1:0]      k;
    logic [RW-1:0]       cur_row;
    logic [CW-1:0]       cur_col;
    logic                cur_fill;
    logic [RW-1:0]       inc_row;
    logic [SW-1:0]       have;
    logic [SW-1:0]       cap;
    logic [SW-1:0]       shown;
    logic [SW-1:0]       cur1;
    logic [SW:0]         start_w;
    logic                hit;
    logic [RW-1:0]       n_row;
    logic [CW-1:0]       n_col;
    logic                n_fill;
    tsr_pkg::t_mem_req   n_req;

    always_comb begin
        k        = (int'(i_instance_req) < CONSOLES) ? CNW'(i_instance_req) : '0;
        cur_row  = r_cur_row[k];
        cur_col  = r_cur_col[k];
        cur_fill = r_filled[k];
        inc_row  = (cur_row == RW'(ROWS - 1)) ? '0 : cur_row + 1'b1;

        have  = cur_fill ? SW'(ROWS) : SW'(cur_row) + 1'b1;
        cap   = (SW'(i_window_rows) > SW'(ROWS)) ? SW'(ROWS) : SW'(i_window_rows);
        shown = (have < cap) ? have : cap;
        cur1  = SW'(cur_row) + 1'b1;
        start_w = (cur1 >= shown) ? {1'b0, cur1 - shown}
                                  : {1'b0, cur1} + (SW+1)'(ROWS) - {1'b0, shown};
        hit   = (shown != '0) && (SW'(i_view_row) < shown);

        n_row  = cur_row;
        n_col  = cur_col;
        n_fill = cur_fill;

        n_req            = '0;
        n_req.op         = tsr_pkg::OP_NOP;
        n_req.console    = tsr_pkg::CON_W'(k);
        n_req.row        = tsr_pkg::ROW_W'(cur_row);
        n_req.chr        = i_char_code;
        n_req.view_row   = i_view_row;

        case (i_cmd)
            tsr_pkg::CMD_PUT: begin
                if (i_char_code == tsr_pkg::CH_LF) begin
                    n_row = inc_row;
                    n_col = '0;
                    if (inc_row == '0) begin
                        n_fill = 1'b1;
                    end
                    n_req.op  = tsr_pkg::OP_LEN;
                    n_req.row = tsr_pkg::ROW_W'(inc_row);
                    n_req.len = '0;
                end else if (i_char_code == tsr_pkg::CH_BS ||
                             i_char_code == tsr_pkg::CH_DEL) begin
                    if (cur_col != '0) begin
                        n_col     = cur_col - 1'b1;
                        n_req.op  = tsr_pkg::OP_LEN;
                        n_req.len = cur_col - 1'b1;
                    end
                end else if (i_char_code == tsr_pkg::CH_CR ||
                             i_char_code < tsr_pkg::CH_SPACE) begin
                    n_req.op = tsr_pkg::OP_NOP;
                end else begin
                    // full line wraps first
                    if (int'(cur_col) >= COLS) begin
                        n_row = inc_row;
                        n_col = '0;
                        if (inc_row == '0) begin
                            n_fill = 1'b1;
                        end
                    end
                    n_req.op  = tsr_pkg::OP_CHAR;
                    n_req.row = tsr_pkg::ROW_W'(n_row);
                    n_req.col = n_col;
                    n_req.len = n_col + 1'b1;
                    n_col     = n_col + 1'b1;
                end
            end
            tsr_pkg::CMD_CLEAR: begin
                n_row    = '0;
                n_col    = '0;
                n_fill   = 1'b0;
                n_req.op = tsr_pkg::OP_CLEAR;
            end
            tsr_pkg::CMD_READ: begin
                n_req.op    = tsr_pkg::OP_READ;
                n_req.row   = tsr_pkg::ROW_W'(start_w[RW-1:0]);
                n_req.col   = CW'(i_view_col);
                n_req.hit   = hit;
                n_req.shown = tsr_pkg::SHOWN_W'(shown);
            end
            default: begin
                n_req.op = tsr_pkg::OP_NOP;
            end
        endcase

        n_req.cursor_col = tsr_pkg::CCOL_W'(n_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CONSOLES; i++) begin
                r_cur_row[i] <= '0;
                r_cur_col[i] <= '0;
            end
            r_filled <= '0;
        end else if (i_accept) begin
            r_cur_row[k] <= n_row;
            r_cur_col[k] <= n_col;
            r_filled[k]  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_req <= n_req;
        end
    end

    assign o_req = r_req;

endmodule

`default_nettype wire

// ===== hw/rtl/tsr_store.sv =====
// ----------------------------------------------------------------------------
// tsr_store
// Character memory and row length memory with per-row valid bits.
// Executes one request per advance; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_store #(
    parameter int ROWS     = tsr_pkg::ROWS_DEF,
    parameter int COLS     = tsr_pkg::COLS_DEF,
    parameter int CONSOLES = tsr_pkg::CONSOLES_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_en,
    input  wire                            i_s1_vld,
    input  tsr_pkg::t_mem_req              i_req,
    output logic [7:0]                     o_rd_char,
    output logic [tsr_pkg::COL_W-1:0]      o_rd_len,
    output logic                           o_rd_vld,
    output tsr_pkg::t_rd_info              o_info
);

    localparam int NROW  = CONSOLES * ROWS;
    localparam int NCHAR = NROW * COLS;
    localparam int LIW   = $clog2(NROW);
    localparam int CIW   = (NCHAR > 1) ? $clog2(NCHAR) : 1;
    localparam int RSW   = tsr_pkg::ROW_W + 1;

    logic [7:0]                r_char_mem [NCHAR];
    logic [tsr_pkg::COL_W-1:0] r_len_mem  [NROW];
    logic                      r_len_vld  [NROW];

    logic [7:0]                r_rd_char;
    logic [tsr_pkg::COL_W-1:0] r_rd_len;
    logic                      r_rd_vld;
    tsr_pkg::t_rd_info         r_info;

    logic [RSW-1:0]            row_sum;
    logic [tsr_pkg::ROW_W-1:0] row_eff;
    int                        lin;
    logic [LIW-1:0]            lidx;
    logic [CIW-1:0]            cidx;
    logic                      do_wr;
    tsr_pkg::t_rd_info         info;

    always_comb begin
        row_sum = {1'b0, i_req.row} + RSW'(i_req.view_row);
        if (i_req.op == tsr_pkg::OP_READ) begin
            row_eff = (row_sum >= RSW'(ROWS)) ? tsr_pkg::ROW_W'(row_sum - RSW'(ROWS))
                                              : tsr_pkg::ROW_W'(row_sum);
        end else begin
            row_eff = i_req.row;
        end
        lin   = int'(i_req.console) * ROWS + int'(row_eff);
        lidx  = LIW'(lin);
        cidx  = CIW'(lin * COLS + int'(i_req.col));
        do_wr = i_en && i_s1_vld &&
                (i_req.op == tsr_pkg::OP_LEN || i_req.op == tsr_pkg::OP_CHAR);

        info.hit        = (i_req.op == tsr_pkg::OP_READ) && i_req.hit;
        info.col        = i_req.col;
        info.shown      = i_req.shown;
        info.cursor_col = i_req.cursor_col;
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_s1_vld && i_req.op == tsr_pkg::OP_CHAR) begin
            r_char_mem[cidx] <= i_req.chr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_len_mem[lidx] <= i_req.len;
        end
    end

    for (genvar g = 0; g < NROW; g++) begin : g_vld
        localparam int CID = g / ROWS;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_len_vld[g] <= 1'b0;
            end else if (do_wr && lidx == LIW'(g)) begin
                r_len_vld[g] <= 1'b1;
            end else if (i_en && i_s1_vld && i_req.op == tsr_pkg::OP_CLEAR &&
                         int'(i_req.console) == CID) begin
                r_len_vld[g] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_char <= r_char_mem[cidx];
            r_rd_len  <= r_len_mem[lidx];
            r_rd_vld  <= r_len_vld[lidx];
            r_info    <= info;
        end
    end

    assign o_rd_char = r_rd_char;
    assign o_rd_len  = r_rd_len;
    assign o_rd_vld  = r_rd_vld;
    assign o_info    = r_info;

endmodule

`default_nettype wire

// ===== hw/rtl/text_scrollback_ring.sv =====
// ----------------------------------------------------------------------------
// text_scrollback_ring
// Multi-console text scrollback ring with put, clear and cell read requests.
//
// Slave stream: tuser carries the command (put, clear, read); tdata carries
// console, character, window rows, view row and view column.
// Master stream: one result per request: cell character, visible rows and
// the console's write column after the request.
// A result passes two register stages: the registered memory request and
// the registered read data. Throughput: one request per cycle while the
// receiver takes results. Console state is updated at acceptance; the
// memory access (one character store and one row length access) uses the
// registered request, and the registered read data forms the result.
// Reset clears all cursors, fill flags and row length valid bits at once;
// no clearing pass. The character store is not cleared.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and tready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module text_scrollback_ring #(
    parameter int ROWS     = tsr_pkg::ROWS_DEF,
    parameter int COLS     = tsr_pkg::COLS_DEF,
    parameter int CONSOLES = tsr_pkg::CONSOLES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // [1:0] instance_req, [9:2] char_code, [15:10] window_rows,
    // [20:16] view_row, [27:21] view_col
    input  wire  [31:0] i_s_tdata,
    // [1:0] cmd
    input  wire  [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // [7:0] cell_char, [13:8] visible_rows, [20:14] cursor_col
    output logic [23:0] o_m_tdata
);

    logic                      r_s1_vld;
    logic                      r_s2_vld;
    logic                      en;
    logic                      accept;
    tsr_pkg::t_mem_req         req;
    logic [7:0]                rd_char;
    logic [tsr_pkg::COL_W-1:0] rd_len;
    logic                      rd_vld;
    tsr_pkg::t_rd_info         info;
    logic [7:0]                cell_char;

    assign en     = !r_s2_vld || i_m_tready;
    assign accept = i_s_tvalid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= accept;
            r_s2_vld <= r_s1_vld;
        end
    end

    tsr_console_ctrl #(
        .ROWS     (ROWS),
        .COLS     (COLS),
        .CONSOLES (CONSOLES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_cmd          (i_s_tuser),
        .i_instance_req (i_s_tdata[1:0]),
        .i_char_code    (i_s_tdata[9:2]),
        .i_window_rows  (i_s_tdata[15:10]),
        .i_view_row     (i_s_tdata[20:16]),
        .i_view_col     (i_s_tdata[27:21]),
        .o_req          (req)
    );

    tsr_store #(
        .ROWS     (ROWS),
        .COLS     (COLS),
        .CONSOLES (CONSOLES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_s1_vld  (r_s1_vld),
        .i_req     (req),
        .o_rd_char (rd_char),
        .o_rd_len  (rd_len),
        .o_rd_vld  (rd_vld),
        .o_info    (info)
    );

    // past line end or out of view reads as zero
    assign cell_char = (info.hit && rd_vld && (info.col < rd_len)) ? rd_char : 8'd0;

    assign o_s_tready = en;
    assign o_m_tvalid = r_s2_vld;
    assign o_m_tdata  = {3'd0, info.cursor_col, info.shown, cell_char};

endmodule

`default_nettype wire
